// ===== hdl/burst_trimmed_mean_filter_macros.svh =====
// assertion macros for the burst trimmed mean filter
`ifndef BURST_TRIMMED_MEAN_FILTER_MACROS_SVH
`define BURST_TRIMMED_MEAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define BTMF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// next-cycle implication, checked outside reset
`define BTMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define BTMF_ASSERT_IMP(label, clk, rst, ante, cons)
`define BTMF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/btmf_pkg.sv =====
package btmf_pkg;

   // fixed field widths of the channels
   localparam int SAMPLE_W = 12;
   localparam int MEAN_W   = 12;

   // control from the sequencer to every cell of the chain
   typedef struct packed {
      logic insert;
      logic clear;
   } cell_ctl_type;

   // flags a cell hands to its right-hand neighbour
   typedef struct packed {
      logic valid;
      logic gt;
   } cell_flag_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/btmf_if.sv =====
// request channel: one converter sample
interface btmf_req_if;
   logic                          valid;
   logic                          ready;
   logic [btmf_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// response channel: one trimmed mean per burst
interface btmf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [btmf_pkg::MEAN_W-1:0] trimmed_mean;

   modport source (output valid, output trimmed_mean, input ready);
   modport sink (input valid, input trimmed_mean, output ready);
endinterface

// ===== hdl/burst_trimmed_mean_filter.sv =====
// Burst trimmed mean filter.
// Requests (req_bus) carry one 12-bit converter sample each; a sample is taken at
// a rising clock edge with valid and ready both high. Every BURST_LEN samples form
// a burst. Each sample is inserted into a sorted row of BURST_LEN cells in the
// cycle it is taken, so inside a burst one sample is accepted per cycle.
// After the last sample of a burst the KEEP_COUNT middle-ranked cells are summed,
// one cell per cycle with ready low, then the row is emptied and the next burst
// may start while a reciprocal multiplier forms sum / KEEP_COUNT.
// The response (rsp_bus) is formed through the divider's product register and
// its busy and done flags, and is then loaded into the output register.
// The response sits in an output register until taken; if the receiver stalls,
// samples of the next burst are still accepted, but its last sample waits until
// the previous response has left and the divider is idle.
// Synchronous reset empties the cell row, clears the fill count and drops any
// pending response.
`include "burst_trimmed_mean_filter_macros.svh"

module burst_trimmed_mean_filter #(
   parameter int BURST_LEN   = 64,
   parameter int KEEP_COUNT  = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   btmf_req_if.sink     req_bus,
   btmf_rsp_if.source   rsp_bus
);

   localparam int FIRST_KEPT = (BURST_LEN / 2) - (KEEP_COUNT / 2);
   localparam int CNT_W      = $clog2(BURST_LEN);
   localparam int KI_W       = $clog2(KEEP_COUNT);
   localparam int SUM_W      = SAMPLE_BITS + $clog2(KEEP_COUNT);
   localparam int IN_EXT_W   = (SAMPLE_BITS > btmf_pkg::SAMPLE_W) ?
                               SAMPLE_BITS : btmf_pkg::SAMPLE_W;
   localparam int OUT_EXT_W  = (SAMPLE_BITS > btmf_pkg::MEAN_W) ?
                               SAMPLE_BITS : btmf_pkg::MEAN_W;

   // sequencer states
   localparam logic ST_FILL = 1'b0;
   localparam logic ST_ACC  = 1'b1;

   logic                          state_ff;
   logic                          state_in;
   logic [CNT_W-1:0]              fill_cnt_ff;
   logic [CNT_W-1:0]              fill_cnt_in;
   logic [KI_W-1:0]               idx_ff;
   logic [KI_W-1:0]               idx_in;
   logic [SUM_W-1:0]              sum_ff;
   logic [SUM_W-1:0]              sum_next;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [btmf_pkg::MEAN_W-1:0]   rsp_mean_ff;
   logic [btmf_pkg::MEAN_W-1:0]   rsp_mean_in;

   logic                          req_accept;
   logic                          rsp_accept;
   logic                          last_slot;
   logic                          acc_last;
   logic [IN_EXT_W-1:0]           sample_wide;
   logic [SAMPLE_BITS-1:0]        sample_cut;
   logic [CNT_W-1:0]              kept_index;
   logic [SAMPLE_BITS-1:0]        kept_value;
   logic [SAMPLE_BITS-1:0]        quotient;
   logic [OUT_EXT_W-1:0]          quotient_wide;

   btmf_pkg::cell_ctl_type        cell_ctl;
   btmf_pkg::div_status_type      div_status;
   logic [SAMPLE_BITS-1:0]        cell_value [BURST_LEN];
   btmf_pkg::cell_flag_type       cell_flag  [BURST_LEN];

   // incoming sample masked to the sample width
   assign sample_wide = IN_EXT_W'(req_bus.sample);
   assign sample_cut  = sample_wide[SAMPLE_BITS-1:0];

   // handshakes
   assign last_slot     = fill_cnt_ff == CNT_W'(BURST_LEN - 1);
   assign req_bus.ready = (state_ff == ST_FILL) &&
                          !(last_slot && (div_status.busy || div_status.done ||
                                          rsp_valid_ff));
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_accept    = rsp_valid_ff && rsp_bus.ready;

   // middle ranks read one per cycle
   assign acc_last   = (state_ff == ST_ACC) && (idx_ff == KI_W'(KEEP_COUNT - 1));
   assign kept_index = CNT_W'(FIRST_KEPT) + CNT_W'(idx_ff);
   assign kept_value = cell_value[kept_index];
   assign sum_next   = sum_ff + SUM_W'(kept_value);

   assign cell_ctl.insert = req_accept;
   assign cell_ctl.clear  = acc_last;

   // sorted insertion row, smallest value in cell 0
   genvar g;
   generate
      for (g = 0; g < BURST_LEN; g++) begin : g_cell
         if (g == 0) begin : g_head
            btmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (cell_ctl),
               .new_sample (sample_cut),
               .left_value ('0),
               .left_flag  ('0),
               .value      (cell_value[g]),
               .flag       (cell_flag[g])
            );
         end else begin : g_body
            btmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (cell_ctl),
               .new_sample (sample_cut),
               .left_value (cell_value[g-1]),
               .left_flag  (cell_flag[g-1]),
               .value      (cell_value[g]),
               .flag       (cell_flag[g])
            );
         end
      end
   endgenerate

   // division by the kept count
   btmf_div #(
      .SUM_W   (SUM_W),
      .DIVISOR (KEEP_COUNT),
      .Q_W     (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (acc_last),
      .dividend (sum_next),
      .status   (div_status),
      .quotient (quotient)
   );

   assign quotient_wide = OUT_EXT_W'(quotient);
   assign rsp_mean_in   = quotient_wide[btmf_pkg::MEAN_W-1:0];

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      fill_cnt_in = fill_cnt_ff;
      idx_in      = idx_ff;
      unique case (state_ff)
         ST_FILL: begin
            idx_in = '0;
            if (req_accept) begin
               if (last_slot) begin
                  fill_cnt_in = '0;
                  state_in    = ST_ACC;
               end else begin
                  fill_cnt_in = fill_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_ACC: begin
            idx_in = idx_ff + KI_W'(1);
            if (acc_last) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (div_status.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_cnt_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // running sum of the kept ranks; response mean captured on divider done
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_next;
      end
      if (div_status.done) begin
         rsp_mean_ff <= rsp_mean_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.trimmed_mean = rsp_mean_ff;

   // checks
   `BTMF_ASSERT_NEXT(a_last_starts_acc, clock, reset, req_accept && last_slot, state_ff == ST_ACC)
   `BTMF_ASSERT_IMP(a_done_into_empty, clock, reset, div_status.done, !rsp_valid_ff)
   `BTMF_ASSERT_IMP(a_acc_while_idle_div, clock, reset, state_ff == ST_ACC, !div_status.busy && !div_status.done && !rsp_valid_ff)
   `BTMF_ASSERT_IMP(a_row_sorted, clock, reset, cell_flag[FIRST_KEPT].valid && cell_flag[FIRST_KEPT + 1].valid, cell_value[FIRST_KEPT] <= cell_value[FIRST_KEPT + 1])

endmodule

// ===== hdl/btmf_cell.sv =====
module btmf_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  btmf_pkg::cell_ctl_type   ctl,
   input  logic [SAMPLE_BITS-1:0]   new_sample,
   input  logic [SAMPLE_BITS-1:0]   left_value,
   input  btmf_pkg::cell_flag_type  left_flag,
   output logic [SAMPLE_BITS-1:0]   value,
   output btmf_pkg::cell_flag_type  flag
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic                   valid_ff;
   logic                   valid_in;

   // this slot lies at or beyond the insertion point
   assign flag.gt    = !valid_ff || (value_ff > new_sample);
   assign flag.valid = valid_ff;
   assign value      = value_ff;

   // clear, keep, shift in from the left, or take the new sample
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && flag.gt) begin
         if (left_flag.gt) begin
            value_in = left_value;
            valid_in = left_flag.valid;
         end else begin
            value_in = new_sample;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hdl/btmf_div.sv =====
module btmf_div #(
   parameter int SUM_W   = 15,
   parameter int DIVISOR = 8,
   parameter int Q_W     = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [SUM_W-1:0]          dividend,
   output btmf_pkg::div_status_type  status,
   output logic [Q_W-1:0]            quotient
);

   // floor(x / DIVISOR) equals (x * RECIP) >> SHIFT for every x below 2**SUM_W
   localparam int     SHIFT = SUM_W + $clog2(DIVISOR);
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) /
                              longint'(DIVISOR);
   localparam int     RW    = SUM_W + 1;
   localparam int     PW    = SUM_W + RW;

   logic          busy_ff;
   logic          done_ff;
   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;
   logic [RW-1:0] recip;

   // reciprocal multiply, quotient taken from the high bits
   assign recip    = RW'(RECIP);
   assign prod_in  = PW'(dividend) * PW'(recip);
   assign quotient = prod_ff[SHIFT +: Q_W];

   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // control: busy follows start, then done follows busy
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

endmodule
